### rtl/core/exclusion_change_tracker_assert.svh
`ifndef EXCLUSION_CHANGE_TRACKER_ASSERT_SVH
`define EXCLUSION_CHANGE_TRACKER_ASSERT_SVH

// property checked on clk with reset masking
`define ECT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// property checked on clk, reset included
`define ECT_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### rtl/core/ect_pkg.sv
package ect_pkg;

  localparam int TABLE_ENTRIES_DEF = 64;
  localparam int CODE_BITS_DEF     = 16;

  localparam int CYCLE_W  = 32;
  localparam int TARGET_W = 64;
  localparam int CODE_W   = 16;
  localparam int CAUSE_W  = 4;

  // input tdata layout
  localparam int IN_CYC_LSB   = 0;
  localparam int IN_DONE_BIT  = IN_CYC_LSB + CYCLE_W;
  localparam int IN_TGT_LSB   = IN_DONE_BIT + 1;
  localparam int IN_EXCL_BIT  = IN_TGT_LSB + TARGET_W;
  localparam int IN_CODE_LSB  = IN_EXCL_BIT + 1;
  localparam int IN_CAUSE_LSB = IN_CODE_LSB + CODE_W;
  localparam int IN_USED_W    = IN_CAUSE_LSB + CAUSE_W;
  localparam int IN_DATA_W    = ((IN_USED_W + 7) / 8) * 8;

  // output tdata layout
  localparam int OUT_CYC_LSB    = 0;
  localparam int OUT_TGT_LSB    = OUT_CYC_LSB + CYCLE_W;
  localparam int OUT_PCODE_LSB  = OUT_TGT_LSB + TARGET_W;
  localparam int OUT_PCAUSE_LSB = OUT_PCODE_LSB + CODE_W;
  localparam int OUT_CCODE_LSB  = OUT_PCAUSE_LSB + CAUSE_W;
  localparam int OUT_CCAUSE_LSB = OUT_CCODE_LSB + CODE_W;
  localparam int OUT_FULL_BIT   = OUT_CCAUSE_LSB + CAUSE_W;
  localparam int OUT_USED_W     = OUT_FULL_BIT + 1;
  localparam int OUT_DATA_W     = ((OUT_USED_W + 7) / 8) * 8;

  localparam logic OP_OBSERVE = 1'b0;
  localparam logic OP_CLEAR   = 1'b1;

  typedef enum logic [1:0] {
    KIND_ENTERED = 2'd0,
    KIND_CHANGED = 2'd1,
    KIND_EXITED  = 2'd2
  } ect_kind_t;

  typedef struct packed {
    logic load;    // input transaction taken
    logic sweep;   // write one invalid entry at the index counter
    logic scan;    // read one entry at the index counter
    logic commit;  // apply the table update and load the result
  } ect_cmd_t;

  typedef struct packed {
    logic in_clear;
    logic in_track;
    logic idx_last;
    logic emit;
    logic out_busy;
  } ect_sts_t;

endpackage

### rtl/core/ect_ram.sv
module ect_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

### rtl/core/ect_ctrl.sv
module ect_ctrl import ect_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_tvalid,
  output logic     in_tready,
  input  ect_sts_t sts,
  output ect_cmd_t cmd
);

  typedef enum logic [2:0] {
    S_INIT,
    S_IDLE,
    S_SCAN,
    S_DRAIN,
    S_DECIDE
  } state_t;

  state_t state_r, state_nxt;
  logic   in_tready_r;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_INIT: begin
        cmd.sweep = 1'b1;
        if (sts.idx_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_tvalid && in_tready_r) begin
          cmd.load = 1'b1;
          priority if (sts.in_clear) begin
            state_nxt = S_INIT;
          end else if (sts.in_track) begin
            state_nxt = S_SCAN;
          end else begin
            state_nxt = S_IDLE;
          end
        end
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.idx_last) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_nxt = S_DECIDE;
      end
      S_DECIDE: begin
        // hold the decision while it emits an event and a pending result is still stalled
        if (!(sts.emit && sts.out_busy)) begin
          cmd.commit = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_INIT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_INIT;
      in_tready_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      in_tready_r <= (state_nxt == S_IDLE);
    end
  end

  assign in_tready = in_tready_r;

endmodule

### rtl/core/ect_datapath.sv
module ect_datapath import ect_pkg::*; #(
  parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF,
  parameter int CODE_BITS     = CODE_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic [IN_DATA_W-1:0]  in_tdata,
  input  logic                  in_tuser,
  input  ect_cmd_t              cmd,
  output ect_sts_t              sts,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,
  output logic [1:0]            out_tuser
);

  localparam int IDX_W  = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int SC_W   = (CODE_BITS < CODE_W) ? CODE_BITS : CODE_W;
  localparam int WORD_W = 1 + TARGET_W + SC_W + CAUSE_W;
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(TABLE_ENTRIES - 1);

  // item registers
  logic [CYCLE_W-1:0]  cyc_r;
  logic [TARGET_W-1:0] tgt_r;
  logic                excl_r;
  logic [SC_W-1:0]     code_r;
  logic [CAUSE_W-1:0]  cause_r;

  // scan state
  logic [IDX_W-1:0]    idx_r;
  logic                rvalid_r;
  logic [IDX_W-1:0]    ridx_r;
  logic                found_r;
  logic [IDX_W-1:0]    found_idx_r;
  logic [SC_W-1:0]     pcode_r;
  logic [CAUSE_W-1:0]  pcause_r;
  logic                free_r;
  logic [IDX_W-1:0]    free_idx_r;

  // result register
  logic                  out_valid_r;
  logic [OUT_DATA_W-1:0] out_data_r;
  logic [1:0]            out_kind_r;

  logic [WORD_W-1:0]   rword;
  logic                w_valid;
  logic [TARGET_W-1:0] w_tgt;
  logic [SC_W-1:0]     w_code;
  logic [CAUSE_W-1:0]  w_cause;

  logic                dec_emit;
  logic                dec_we;
  logic [IDX_W-1:0]    dec_addr;
  logic [WORD_W-1:0]   dec_data;
  ect_kind_t           dec_kind;
  logic                dec_full;
  logic [CODE_W-1:0]   dec_pcode;
  logic [CAUSE_W-1:0]  dec_pcause;
  logic [CODE_W-1:0]   dec_ccode;
  logic [CAUSE_W-1:0]  dec_ccause;

  logic                ram_we;
  logic [IDX_W-1:0]    ram_waddr;
  logic [WORD_W-1:0]   ram_wdata;

  assign {w_valid, w_tgt, w_code, w_cause} = rword;

  assign sts.in_clear = (in_tuser == OP_CLEAR);
  assign sts.in_track = in_tdata[IN_DONE_BIT] &&
                        (in_tdata[IN_TGT_LSB +: TARGET_W] != '0);
  assign sts.idx_last = (idx_r == IDX_LAST);
  assign sts.emit     = dec_emit;
  assign sts.out_busy = out_valid_r && !out_tready;

  always_comb begin
    dec_emit   = 1'b0;
    dec_we     = 1'b0;
    dec_addr   = found_idx_r;
    dec_data   = {1'b1, tgt_r, code_r, cause_r};
    dec_kind   = KIND_ENTERED;
    dec_full   = 1'b0;
    dec_pcode  = CODE_W'(pcode_r);
    dec_pcause = pcause_r;
    dec_ccode  = CODE_W'(code_r);
    dec_ccause = cause_r;
    priority if (excl_r && !found_r) begin
      dec_emit   = 1'b1;
      dec_full   = !free_r;
      dec_we     = free_r;
      dec_addr   = free_idx_r;
      dec_pcode  = '0;
      dec_pcause = '0;
    end else if (excl_r) begin
      dec_kind = KIND_CHANGED;
      dec_emit = (pcode_r != code_r) || (pcause_r != cause_r);
      dec_we   = dec_emit;
    end else if (found_r) begin
      dec_kind   = KIND_EXITED;
      dec_emit   = 1'b1;
      dec_we     = 1'b1;
      dec_data   = '0;
      dec_ccode  = '0;
      dec_ccause = '0;
    end else begin
      dec_emit = 1'b0;
    end
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = idx_r;
    ram_wdata = '0;
    priority if (cmd.sweep) begin
      ram_we = 1'b1;
    end else if (cmd.commit) begin
      ram_we    = dec_we;
      ram_waddr = dec_addr;
      ram_wdata = dec_data;
    end else begin
      ram_we = 1'b0;
    end
  end

  ect_ram #(
    .WIDTH (WORD_W),
    .DEPTH (TABLE_ENTRIES),
    .AW    (IDX_W)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (cmd.scan),
    .raddr (idx_r),
    .rdata (rword)
  );

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cyc_r   <= in_tdata[IN_CYC_LSB +: CYCLE_W];
      tgt_r   <= in_tdata[IN_TGT_LSB +: TARGET_W];
      excl_r  <= in_tdata[IN_EXCL_BIT];
      code_r  <= in_tdata[IN_CODE_LSB +: SC_W];
      cause_r <= in_tdata[IN_CAUSE_LSB +: CAUSE_W];
    end
    if (rvalid_r && w_valid && (w_tgt == tgt_r) && !found_r) begin
      found_idx_r <= ridx_r;
      pcode_r     <= w_code;
      pcause_r    <= w_cause;
    end
    if (rvalid_r && !w_valid && !free_r) begin
      free_idx_r <= ridx_r;
    end
    ridx_r <= idx_r;
    if (cmd.commit && dec_emit) begin
      out_kind_r <= dec_kind;
      out_data_r <= {{(OUT_DATA_W - OUT_USED_W){1'b0}}, dec_full, dec_ccause, dec_ccode,
                     dec_pcause, dec_pcode, tgt_r, cyc_r};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r       <= '0;
      rvalid_r    <= 1'b0;
      found_r     <= 1'b0;
      free_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      rvalid_r <= cmd.scan;
      if (cmd.load) begin
        idx_r   <= '0;
        found_r <= 1'b0;
        free_r  <= 1'b0;
      end else begin
        if (cmd.sweep || cmd.scan) begin
          idx_r <= (idx_r == IDX_LAST) ? '0 : idx_r + 1'b1;
        end
        if (rvalid_r && w_valid && (w_tgt == tgt_r)) begin
          found_r <= 1'b1;
        end
        if (rvalid_r && !w_valid) begin
          free_r <= 1'b1;
        end
      end
      if (cmd.commit && dec_emit) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_kind_r;

endmodule

### rtl/core/exclusion_change_tracker.sv
// exclusion change tracker
// in_* channel: one observed target, or a table clear when in_tuser is set.
// out_* channel: one entered / changed / exited event, kind on out_tuser.
// after an observe transaction is accepted, in_tready stays low until write-back;
// the table lives in a single-port-read RAM that is scanned one entry per cycle,
// followed by a drain state for the last read and a decide state that writes
// back. the event shows on out_tvalid the cycle after the write-back.
// incomplete cycles and target zero are accepted and dropped without a table scan.
// a clear transaction sweeps the table before in_tready returns.
// after reset the same sweep runs with in_tready low.
// a result waits in the output register while out_tready is low; the next
// item is still accepted and scanned, and only its update waits for the
// output register to drain.
module exclusion_change_tracker import ect_pkg::*; #(
  parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF,
  parameter int CODE_BITS     = CODE_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // cycle number, cycle done flag, target, excluded flag, code, cause
  input  logic [IN_DATA_W-1:0]  in_tdata,
  // operation
  input  logic                  in_tuser,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // cycle number, target, prior code, prior cause,
  // new code, new cause, full flag
  output logic [OUT_DATA_W-1:0] out_tdata,
  // event kind
  output logic [1:0]            out_tuser
);

  ect_cmd_t cmd;
  ect_sts_t sts;

  ect_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  ect_datapath #(
    .TABLE_ENTRIES (TABLE_ENTRIES),
    .CODE_BITS     (CODE_BITS)
  ) u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .cmd        (cmd),
    .sts        (sts),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule

### rtl/core/ect_checker.sv
`include "exclusion_change_tracker_assert.svh"

module ect_checker import ect_pkg::*; (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_tvalid,
  input logic                  in_tready,
  input logic [IN_DATA_W-1:0]  in_tdata,
  input logic                  in_tuser,
  input logic                  out_tvalid,
  input logic                  out_tready,
  input logic [OUT_DATA_W-1:0] out_tdata,
  input logic [1:0]            out_tuser
);

  `ECT_ASSERT_RST(a_reset_quiet, !rst_n |=> (!out_tvalid && !in_tready), "ports active after reset")

  `ECT_ASSERT(a_full_entered, (out_tvalid && out_tdata[OUT_FULL_BIT]) |-> (out_tuser == KIND_ENTERED), "table_full on non-entered event")

  `ECT_ASSERT(a_exit_zero, (out_tvalid && (out_tuser == KIND_EXITED)) |-> (out_tdata[OUT_FULL_BIT-1:OUT_CCODE_LSB] == '0), "exited event carries a current pair")

  `ECT_ASSERT(a_change_differs, (out_tvalid && (out_tuser == KIND_CHANGED)) |-> (out_tdata[OUT_CCODE_LSB-1:OUT_PCODE_LSB] != out_tdata[OUT_FULL_BIT-1:OUT_CCODE_LSB]), "changed event with equal pairs")

  `ECT_ASSERT(a_out_hold, (out_tvalid && !out_tready) |=> (out_tvalid && $stable(out_tdata) && $stable(out_tuser)), "stalled result changed")

endmodule

bind exclusion_change_tracker ect_checker u_ect_checker (.*);

### dv/exclusion_change_tracker_tb.sv
`timescale 1ns / 100ps

module exclusion_change_tracker_tb;
  import ect_pkg::*;

  localparam int N_SLOTS      = TABLE_ENTRIES_DEF;
  localparam int RANDOM_ITEMS = 1680;
  localparam int HOLD_CYCLES  = 400;
  localparam int STALL_LIMIT  = 5000;
  localparam bit [CODE_W-1:0] CODE_MASK = CODE_W'((64'd1 << CODE_BITS_DEF) - 64'd1);

  // one observed target, lowest field last
  typedef struct packed {
    bit [CAUSE_W-1:0]  cause;
    bit [CODE_W-1:0]   code;
    bit                excl;
    bit [TARGET_W-1:0] target;
    bit                done;
    bit [CYCLE_W-1:0]  cyc;
  } obs_t;

  // event payload as carried on out_tdata
  typedef struct packed {
    logic               full;
    logic [CAUSE_W-1:0] ccause;
    logic [CODE_W-1:0]  ccode;
    logic [CAUSE_W-1:0] pcause;
    logic [CODE_W-1:0]  pcode;
    logic [TARGET_W-1:0] target;
    logic [CYCLE_W-1:0] cyc;
  } ev_data_t;

  typedef struct {
    ect_kind_t kind;
    ev_data_t  data;
  } excl_event_t;

  class exclusion_event_board;
    bit                slot_used  [N_SLOTS];
    bit [TARGET_W-1:0] slot_id    [N_SLOTS];
    bit [CODE_W-1:0]   slot_code  [N_SLOTS];
    bit [CAUSE_W-1:0]  slot_cause [N_SLOTS];
    excl_event_t expected_events[$];
    int failures, n_entered, n_changed, n_exited, n_full, n_clears, n_checked;

    function string show(logic [1:0] kind, ev_data_t d);
      return $sformatf("kind %0d cycle %h target %h prev %h/%h cur %h/%h full %b",
                       kind, d.cyc, d.target, d.pcode, d.pcause, d.ccode, d.ccause,
                       d.full);
    endfunction

    function void flag(string what, string exp_s, string got_s);
      failures++;
      if (failures <= 10)
        $display("MISMATCH %s\n  expected: %s\n  actual:   %s", what, exp_s, got_s);
    endfunction

    // accepted input transaction: update the table copy, queue the event it causes
    function void note_item(logic op, obs_t it);
      int hit, hole;
      excl_event_t e;
      bit [CODE_W-1:0] code;
      hit = -1;
      hole = -1;
      code = it.code & CODE_MASK;
      if (op == OP_CLEAR) begin
        foreach (slot_used[i]) slot_used[i] = 1'b0;
        n_clears++;
        return;
      end
      if (!it.done || it.target == '0) return;
      for (int i = 0; i < N_SLOTS; i++) begin
        if (slot_used[i] && slot_id[i] == it.target && hit < 0) hit = i;
        if (!slot_used[i] && hole < 0) hole = i;
      end
      e.data = '0;
      e.data.cyc = it.cyc;
      e.data.target = it.target;
      if (it.excl && hit < 0) begin
        e.kind = KIND_ENTERED;
        e.data.ccode = code;
        e.data.ccause = it.cause;
        if (hole < 0) begin
          e.data.full = 1'b1;
          n_full++;
        end else begin
          slot_used[hole] = 1'b1;
          slot_id[hole] = it.target;
          slot_code[hole] = code;
          slot_cause[hole] = it.cause;
        end
        n_entered++;
      end else if (it.excl) begin
        if (slot_code[hit] == code && slot_cause[hit] == it.cause) return;
        e.kind = KIND_CHANGED;
        e.data.pcode = slot_code[hit];
        e.data.pcause = slot_cause[hit];
        e.data.ccode = code;
        e.data.ccause = it.cause;
        slot_code[hit] = code;
        slot_cause[hit] = it.cause;
        n_changed++;
      end else if (hit >= 0) begin
        e.kind = KIND_EXITED;
        e.data.pcode = slot_code[hit];
        e.data.pcause = slot_cause[hit];
        slot_used[hit] = 1'b0;
        n_exited++;
      end else begin
        return;
      end
      expected_events = {expected_events, e};
    endfunction

    function void check_event(logic [1:0] kind, ev_data_t got);
      excl_event_t e;
      n_checked++;
      if (expected_events.size() == 0) begin
        flag("event with none pending", "none", show(kind, got));
        return;
      end
      e = expected_events.pop_front();
      if (kind !== e.kind || got.cyc !== e.data.cyc || got.target !== e.data.target ||
          got.pcode !== e.data.pcode || got.pcause !== e.data.pcause ||
          got.ccode !== e.data.ccode || got.ccause !== e.data.ccause ||
          got.full !== e.data.full)
        flag("event fields", show(e.kind, e.data), show(kind, got));
    endfunction

    function void flag_leftovers();
      foreach (expected_events[i])
        flag("event never seen", show(expected_events[i].kind, expected_events[i].data),
             "none");
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  logic                  in_tuser = OP_OBSERVE;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic [1:0]            out_tuser;

  exclusion_event_board board = new();
  bit [TARGET_W-1:0] id_pool [96];
  bit calm = 1'b0;
  int hold_reqs = 0;
  int hold_seen = 0;
  int hold_left = 0;

  exclusion_change_tracker dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  always #5 clk = ~clk;

  // receiver: random stalls, or a long hold-off when one is requested
  always @(negedge clk) begin
    if (hold_reqs != hold_seen) begin
      hold_seen = hold_reqs;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      out_tready = 1'b0;
      hold_left--;
    end else begin
      out_tready = calm || ($urandom_range(99) >= 13);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready)
      board.check_event(out_tuser, out_tdata[OUT_USED_W-1:0]);
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet = 0;
      else quiet++;
    end
    $display("timeout: no transaction for %0d cycles", STALL_LIMIT);
    $display("Regression FAIL");
    $finish;
  end

  // called at a falling edge, returns at the falling edge after acceptance
  task automatic send_item(input logic op, input obs_t it);
    while (!calm && $urandom_range(99) < 13) begin
      in_tvalid = 1'b0;
      @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tuser = op;
    in_tdata = IN_DATA_W'(it);
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    board.note_item(op, it);
    @(negedge clk);
  endtask

  function automatic obs_t make_obs(int pool_n, int excl_pct);
    obs_t o;
    int r;
    o.cyc = $urandom;
    o.done = $urandom_range(99) >= 8;
    r = $urandom_range(99);
    if (r < 4) o.target = '0;
    else if (r < 8) o.target = {$urandom, $urandom};
    else o.target = id_pool[$urandom_range(pool_n - 1)];
    o.excl = $urandom_range(99) < excl_pct;
    // narrow code/cause sets make repeated pairs likely
    case ($urandom_range(3))
      0: o.code = '0;
      1: o.code = 16'h0001;
      2: o.code = 16'hFFFF;
      default: o.code = CODE_W'($urandom);
    endcase
    case ($urandom_range(2))
      0: o.cause = '0;
      1: o.cause = 4'hF;
      default: o.cause = CAUSE_W'($urandom);
    endcase
    return o;
  endfunction

  function automatic obs_t obs(bit [CYCLE_W-1:0] cyc, bit done, bit [TARGET_W-1:0] target,
                               bit excl, bit [CODE_W-1:0] code, bit [CAUSE_W-1:0] cause);
    obs_t o;
    o.cyc = cyc;
    o.done = done;
    o.target = target;
    o.excl = excl;
    o.code = code;
    o.cause = cause;
    return o;
  endfunction

  initial begin : stimulus
    int counted, phase, pool_n, excl_pct, clear_pm;
    logic op;
    obs_t it;
    counted = 0;
    phase = 0;
    id_pool[0] = '1;
    id_pool[1] = 64'd1;
    id_pool[2] = 64'h8000_0000_0000_0000;
    for (int i = 3; i < 96; i++) begin
      id_pool[i] = {$urandom, $urandom};
      if (id_pool[i] == '0) id_pool[i] = 64'd7;
    end

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed: extremes, every event kind and each quiet case
    send_item(OP_CLEAR, obs(32'h1234_5678, 1'b0, 64'hDEAD, 1'b1, 16'h5A5A, 4'h3));
    send_item(OP_OBSERVE, obs('1, 1'b1, '1, 1'b1, '1, '1));
    send_item(OP_OBSERVE, obs(32'd5, 1'b1, '1, 1'b1, '1, '1));
    send_item(OP_OBSERVE, obs(32'd6, 1'b1, '1, 1'b1, '0, '0));
    send_item(OP_OBSERVE, obs(32'd7, 1'b1, '1, 1'b0, 16'h1111, 4'h1));
    send_item(OP_OBSERVE, obs(32'd8, 1'b1, '1, 1'b0, '0, '0));
    send_item(OP_OBSERVE, obs(32'd9, 1'b1, '0, 1'b1, 16'hFFFF, 4'hF));
    send_item(OP_OBSERVE, obs(32'd10, 1'b0, 64'd1, 1'b1, 16'h00FF, 4'h2));
    send_item(OP_OBSERVE, obs('0, 1'b1, 64'd1, 1'b1, 16'h0001, 4'h1));
    send_item(OP_OBSERVE, obs(32'h8000_0000, 1'b1, 64'h8000_0000_0000_0000, 1'b1,
                              16'h8000, 4'h8));
    send_item(OP_OBSERVE, obs(32'd12, 1'b1, 64'd1, 1'b1, 16'h0001, 4'h2));
    send_item(OP_OBSERVE, obs(32'd13, 1'b1, 64'd1, 1'b1, 16'hABCD, 4'h2));
    send_item(OP_CLEAR, obs('1, 1'b1, 64'd1, 1'b1, '1, '1));
    send_item(OP_OBSERVE, obs(32'd14, 1'b1, 64'd1, 1'b0, '0, '0));
    send_item(OP_OBSERVE, obs(32'd15, 1'b1, 64'd1, 1'b1, 16'h7777, 4'h7));
    send_item(OP_OBSERVE, obs(32'd16, 1'b1, 64'd1, 1'b0, '0, '0));

    // back-pressure: receiver holds off while new targets keep coming
    send_item(OP_CLEAR, make_obs(4, 50));
    calm = 1'b1;
    hold_reqs++;
    for (int i = 0; i < 12; i++)
      send_item(OP_OBSERVE, obs($urandom, 1'b1, id_pool[i + 3], 1'b1,
                                CODE_W'($urandom), CAUSE_W'($urandom)));
    calm = 1'b0;

    while (counted < RANDOM_ITEMS) begin
      case (phase % 4)
        0: begin pool_n = 8;  excl_pct = 60; clear_pm = 10; end
        1: begin pool_n = 24; excl_pct = 70; clear_pm = 5;  end
        // wide pool, mostly excluded, no clears: fills the table
        2: begin pool_n = 96; excl_pct = 92; clear_pm = 0;  end
        default: begin pool_n = 4; excl_pct = 50; clear_pm = 10; end
      endcase
      calm = (phase == 1);
      repeat (168) begin
        op = ($urandom_range(999) < clear_pm) ? OP_CLEAR : OP_OBSERVE;
        it = make_obs(pool_n, excl_pct);
        send_item(op, it);
        counted++;
      end
      phase++;
    end
    calm = 1'b0;
    in_tvalid = 1'b0;

    while (board.expected_events.size() != 0) @(posedge clk);
    repeat (N_SLOTS + 8) @(posedge clk);
    board.flag_leftovers();

    $display("covered %0d events checked: %0d entered (%0d with table full), %0d changed,",
             board.n_checked, board.n_entered, board.n_full, board.n_changed);
    $display("  %0d exited, %0d table clears, %0d failures", board.n_exited,
             board.n_clears, board.failures);
    if (board.failures == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule

### filelist.f
+incdir+rtl/core
rtl/core/ect_pkg.sv
rtl/core/ect_ram.sv
rtl/core/ect_ctrl.sv
rtl/core/ect_datapath.sv
rtl/core/exclusion_change_tracker.sv
rtl/core/ect_checker.sv
dv/exclusion_change_tracker_tb.sv
